[sv/chv_pkg.sv]
// chv_pkg: constants, types and a decode function for the cartridge header validator
// no dependencies

package chv_pkg;

  // header offsets
  localparam logic [8:0] OffFirst = 9'h134;
  localparam logic [8:0] OffLast  = 9'h14C;
  localparam logic [8:0] OffColor = 9'h143;
  localparam logic [8:0] OffType  = 9'h147;
  localparam logic [8:0] OffRom   = 9'h148;
  localparam logic [8:0] OffRam   = 9'h149;
  localparam logic [8:0] OffCheck = 9'h14D;

  // rom size codes with irregular bank counts, and the last power-of-two code
  localparam logic [7:0] RomCode72 = 8'h52;
  localparam logic [7:0] RomCode80 = 8'h53;
  localparam logic [7:0] RomCode96 = 8'h54;
  localparam logic [7:0] RomCodeMaxPow = 8'h06;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_CHECKSUM = 3'd1,
    ERR_TYPE     = 3'd2,
    ERR_ROM_SIZE = 3'd3,
    ERR_RAM_SIZE = 3'd4
  } err_t;

  // decoded cartridge type
  typedef struct packed {
    logic       hit;
    logic [2:0] mapper;
    logic       ram;
    logic       batt;
    logic       clk;
    logic       rumble;
  } kind_t;

  // type code table lookup
  function automatic kind_t decode_kind(input logic [7:0] code);
    kind_t k;
    k = '0;
    k.hit = 1'b1;
    case (code)
      8'h00: ;
      8'h01: k.mapper = 3'd1;
      8'h02: begin k.mapper = 3'd1; k.ram = 1'b1; end
      8'h03: begin k.mapper = 3'd1; k.ram = 1'b1; k.batt = 1'b1; end
      8'h05: k.mapper = 3'd2;
      8'h06: begin k.mapper = 3'd2; k.batt = 1'b1; end
      8'h08: k.ram = 1'b1;
      8'h09: begin k.ram = 1'b1; k.batt = 1'b1; end
      8'h0F: begin k.mapper = 3'd3; k.batt = 1'b1; k.clk = 1'b1; end
      8'h10: begin k.mapper = 3'd3; k.ram = 1'b1; k.batt = 1'b1; k.clk = 1'b1; end
      8'h11: k.mapper = 3'd3;
      8'h12: begin k.mapper = 3'd3; k.ram = 1'b1; end
      8'h13: begin k.mapper = 3'd3; k.ram = 1'b1; k.batt = 1'b1; end
      8'h19: k.mapper = 3'd5;
      8'h1A: begin k.mapper = 3'd5; k.ram = 1'b1; end
      8'h1B: begin k.mapper = 3'd5; k.ram = 1'b1; k.batt = 1'b1; end
      8'h1C: begin k.mapper = 3'd5; k.rumble = 1'b1; end
      8'h1D: begin k.mapper = 3'd5; k.ram = 1'b1; k.rumble = 1'b1; end
      8'h1E: begin k.mapper = 3'd5; k.ram = 1'b1; k.batt = 1'b1; k.rumble = 1'b1; end
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

[sv/cartridge_header_validator.sv]
// cartridge_header_validator: streaming header check with one result per check byte
// depends on chv_pkg

// Takes one header byte per cycle, tagged with its offset, and gives one result item
// when the check byte at offset 0x14D arrives. An item passes an input register and
// then a result register, so a result is presented when its check byte enters the
// result register, held while a previous result waits; the running checksum and captured
// codes update as each byte leaves the input register. Bytes at 0x134..0x14C are
// folded into the checksum (0x134 restarts it), bytes at other offsets are dropped.
// The input side keeps accepting while a finished result waits, and stalls only when
// the result register is full, not taken, and a check byte sits in the input register.
module cartridge_header_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] in_byte_offset,
  input  logic [7:0] in_header_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_header_ok,
  output logic [2:0] out_error_code,
  output logic       out_color_support,
  output logic [2:0] out_mapper_kind,
  output logic       out_has_ext_ram,
  output logic       out_has_battery,
  output logic       out_has_clock,
  output logic       out_has_rumble,
  output logic [7:0] out_rom_banks,
  output logic [4:0] out_ram_banks
);
  import chv_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [8:0] s1_off_r;
  logic [7:0] s1_byte_r;

  // header state
  logic [7:0] check_r, check_nxt;
  logic       color_r;
  logic [7:0] type_r;
  logic [7:0] rom_r;
  logic [7:0] ram_r;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       ok_r, ok_nxt;
  err_t       err_r, err_nxt;
  logic       color_out_r, color_out_nxt;
  kind_t      kind_out_r, kind_out_nxt;
  logic [7:0] rom_banks_r, rom_banks_nxt;
  logic [4:0] ram_banks_r, ram_banks_nxt;

  logic  is_check;
  logic  in_range;
  logic  adv;
  kind_t kind;
  logic       rom_ok;
  logic [7:0] rom_banks;
  logic       ram_ok;
  logic [4:0] ram_banks;

  // flow control
  assign is_check = (s1_off_r == OffCheck);
  assign in_range = (s1_off_r >= OffFirst) && (s1_off_r <= OffLast);
  assign adv      = s1_valid_r && (!is_check || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_off_r  <= in_byte_offset;
      s1_byte_r <= in_header_byte;
    end
  end

  // checksum fold
  assign check_nxt = ((s1_off_r == OffFirst) ? 8'd0 : check_r) - s1_byte_r - 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_r <= '0;
      color_r <= 1'b0;
      type_r  <= '0;
      rom_r   <= '0;
      ram_r   <= '0;
    end else if (adv && in_range) begin
      check_r <= check_nxt;
      if (s1_off_r == OffColor) color_r <= s1_byte_r[7];
      if (s1_off_r == OffType)  type_r  <= s1_byte_r;
      if (s1_off_r == OffRom)   rom_r   <= s1_byte_r;
      if (s1_off_r == OffRam)   ram_r   <= s1_byte_r;
    end
  end

  // code decode
  assign kind = decode_kind(type_r);

  always_comb begin
    rom_ok    = 1'b1;
    rom_banks = '0;
    if (rom_r == RomCode72) begin
      rom_banks = 8'd72;
    end else if (rom_r == RomCode80) begin
      rom_banks = 8'd80;
    end else if (rom_r == RomCode96) begin
      rom_banks = 8'd96;
    end else if (rom_r <= RomCodeMaxPow) begin
      rom_banks = 8'd2 << rom_r[2:0];
    end else begin
      rom_ok = 1'b0;
    end
  end

  always_comb begin
    ram_ok    = 1'b1;
    ram_banks = '0;
    case (ram_r)
      8'd0:    ram_banks = 5'd0;
      8'd1:    ram_banks = 5'd1;
      8'd2:    ram_banks = 5'd1;
      8'd3:    ram_banks = 5'd4;
      8'd4:    ram_banks = 5'd16;
      default: ram_ok = 1'b0;
    endcase
  end

  // verdict, first failure wins and later fields read zero
  always_comb begin
    ok_nxt        = 1'b0;
    err_nxt       = ERR_NONE;
    color_out_nxt = 1'b0;
    kind_out_nxt  = '0;
    rom_banks_nxt = '0;
    ram_banks_nxt = '0;
    if (check_r != s1_byte_r) begin
      err_nxt = ERR_CHECKSUM;
    end else begin
      color_out_nxt = color_r;
      if (!kind.hit) begin
        err_nxt = ERR_TYPE;
      end else begin
        kind_out_nxt = kind;
        if (!rom_ok) begin
          err_nxt = ERR_ROM_SIZE;
        end else begin
          rom_banks_nxt = rom_banks;
          if (!ram_ok) begin
            err_nxt = ERR_RAM_SIZE;
          end else begin
            ram_banks_nxt = ram_banks;
            ok_nxt        = 1'b1;
          end
        end
      end
    end
  end

  // result register
  assign out_valid_nxt = (adv && is_check) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_check) begin
      ok_r        <= ok_nxt;
      err_r       <= err_nxt;
      color_out_r <= color_out_nxt;
      kind_out_r  <= kind_out_nxt;
      rom_banks_r <= rom_banks_nxt;
      ram_banks_r <= ram_banks_nxt;
    end
  end

  // outputs
  assign out_valid         = out_valid_r;
  assign out_header_ok     = ok_r;
  assign out_error_code    = err_r;
  assign out_color_support = color_out_r;
  assign out_mapper_kind   = kind_out_r.mapper;
  assign out_has_ext_ram   = kind_out_r.ram;
  assign out_has_battery   = kind_out_r.batt;
  assign out_has_clock     = kind_out_r.clk;
  assign out_has_rumble    = kind_out_r.rumble;
  assign out_rom_banks     = rom_banks_r;
  assign out_ram_banks     = ram_banks_r;

endmodule
